/* hw/rtl/crc12nt_pkg.sv */
// Package: CRC-12 nibble table, hash constants and field widths.
package crc12nt_pkg;

  localparam int unsigned HASH_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [NIB_W-1:0]  nib_t;

  localparam hash_t HASH_INIT = 12'hFFF;

  // Reflected CRC-12 remainder table, one entry per nibble value.
  function automatic hash_t nib_lookup(input nib_t idx);
    hash_t val;
    case (idx)
      4'd0:    val = 12'd0;
      4'd1:    val = 12'd641;
      4'd2:    val = 12'd1282;
      4'd3:    val = 12'd1923;
      4'd4:    val = 12'd2564;
      4'd5:    val = 12'd2181;
      4'd6:    val = 12'd3846;
      4'd7:    val = 12'd3463;
      4'd8:    val = 12'd3079;
      4'd9:    val = 12'd3718;
      4'd10:   val = 12'd2309;
      4'd11:   val = 12'd2948;
      4'd12:   val = 12'd1539;
      4'd13:   val = 12'd1154;
      4'd14:   val = 12'd769;
      4'd15:   val = 12'd384;
      default: val = 12'd0;
    endcase
    return val;
  endfunction

  // One nibble step: table entry XOR hash shifted right by a nibble.
  function automatic hash_t fold_nib(input hash_t h, input nib_t nib);
    hash_t tab;
    tab = nib_lookup(h[NIB_W-1:0] ^ nib);
    return tab ^ (h >> NIB_W);
  endfunction

endpackage

/* hw/rtl/crc12nt_fold.sv */
// Byte fold unit: reload mux plus two nibble table steps, low nibble first.
module crc12nt_fold (
  input  crc12nt_pkg::hash_t hash_in,
  input  logic               reload,
  input  crc12nt_pkg::byte_t data_byte,
  output crc12nt_pkg::hash_t hash_out
);
  import crc12nt_pkg::*;

  hash_t seed;
  hash_t mid;

  assign seed     = reload ? HASH_INIT : hash_in;
  assign mid      = fold_nib(seed, data_byte[NIB_W-1:0]);
  assign hash_out = fold_nib(mid, data_byte[BYTE_W-1:NIB_W]);

endmodule

/* hw/rtl/crc12_nibble_table_hash.sv */
// Top level: streaming CRC-12 nibble table hash with input and result registers.
//
// Takes one message byte per transaction and returns one transaction carrying the
// 12-bit running hash after that byte. The hash starts at 0xFFF after reset, and a
// byte with in_tuser set reloads 0xFFF before it is folded; in_tlast does not clear
// the hash, it is only echoed on out_tlast to mark the complete message hash. Each
// byte passes an input register, then the fold logic (reload mux, two 16-entry table
// lookups and XORs) into the result register; out_tvalid rises as the byte moves from
// the input register into the result register, which waits while the result register
// is held. One byte is accepted every clock while out_tready stays high. The running hash
// register updates as the byte moves into the result register, which is the only loop
// through the fold logic in the design.
module crc12_nibble_table_hash (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,   // last_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] hash_value, [15:12] zero
  output logic        out_tlast   // is_final
);
  import crc12nt_pkg::*;

  // input register stage
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_data_r;
  logic  s1_first_r;
  logic  s1_last_r;

  // result register stage
  logic  out_valid_r, out_valid_nxt;
  hash_t out_hash_r;
  logic  out_last_r;

  // running hash
  hash_t hash_r;
  hash_t hash_nxt;

  logic in_acc;
  logic out_free;
  logic s1_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  crc12nt_fold u_fold (
    .hash_in   (hash_r),
    .reload    (s1_first_r),
    .data_byte (s1_data_r),
    .hash_out  (hash_nxt)
  );

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hash_r      <= HASH_INIT;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        hash_r <= hash_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
    if (s1_adv) begin
      out_hash_r <= hash_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-HASH_W){1'b0}}, out_hash_r};
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------

  // running hash always matches the hash of the transaction just moved out
  a_hash_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (hash_r == out_tdata[HASH_W-1:0]))
    else $error("running hash diverged from result register");

  // an item leaving the input register lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("item lost between input and result register");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // reset leaves the hash at its initial value
  a_reset_init: assert property (@(posedge clk)
    !rst_n |=> (hash_r == HASH_INIT))
    else $error("hash not initialized by reset");

endmodule

/* verif/testbench.sv */
// Testbench for crc12_nibble_table_hash: byte stream in, running CRC-12 hash out, self-checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crc12nt_pkg::*;

  // Shape of one expected result transaction.
  typedef struct packed {
    hash_t hash;
    logic  final_flag;
  } hash_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // first_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [11:0] hash_value, [15:12] zero
  logic        out_tlast;          // is_final

  // Reflected CRC-12 remainders, one per nibble value (own copy for prediction).
  hash_t crc_table [0:15] = '{
    12'd0,    12'd641,  12'd1282, 12'd1923, 12'd2564, 12'd2181, 12'd3846, 12'd3463,
    12'd3079, 12'd3718, 12'd2309, 12'd2948, 12'd1539, 12'd1154, 12'd769,  12'd384
  };

  // Predicted hash register, tracks the block's running hash (hash_r) across transactions.
  hash_t        model_hash = HASH_INIT;
  hash_result_t pending_hashes [$];

  // Idle percentages per side, changed between phases.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  // Cycles left in a forced output hold-off; set by test_output_holdoff, counted down by the sink process.
  int unsigned holdoff_left  = 0;

  int unsigned err_count      = 0;
  int unsigned bytes_sent     = 0;
  int unsigned msgs_closed    = 0;
  int unsigned results_seen   = 0;
  int unsigned stall_cycles   = 0;

  crc12_nibble_table_hash u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Fold a whole byte, low nibble first, into a hash value.
  function automatic hash_t crc12_fold_byte(hash_t h, byte_t d);
    hash_t acc;
    nib_t  nib;
    acc = h;
    for (int k = 0; k < 2; k++) begin
      nib = d[k*NIB_W +: NIB_W];
      acc = crc_table[acc[NIB_W-1:0] ^ nib] ^ (acc >> NIB_W);
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 40)
      $display("testbench: mismatch %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Sink side: random tready per cycle, or a counted hold-off when one is armed.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_tready <= 1'b0;
        holdoff_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Result checker: every result transaction is matched to the oldest prediction.
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready && holdoff_left > 0)
        stall_cycles++;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_hashes.size() == 0) begin
          report_mismatch("unexpected result, out_tdata", int'(out_tdata), 0);
        end else begin
          want = pending_hashes.pop_front();
          if (out_tdata[11:0] !== want.hash)
            report_mismatch("hash_value", int'(out_tdata[11:0]), int'(want.hash));
          if (out_tdata[15:12] !== 4'h0)
            report_mismatch("out_tdata pad", int'(out_tdata[15:12]), 0);
          if (out_tlast !== want.final_flag)
            report_mismatch("is_final", int'(out_tlast), int'(want.final_flag));
        end
      end
    end
  end

  // Send one byte. Starts and ends at a falling edge; valid stays high into the
  // next call unless that call idles first, so valid never toggles within a step.
  task automatic push_byte(byte_t d, logic first, logic last);
    hash_t seed;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge: advance the prediction
    seed       = first ? HASH_INIT : model_hash;
    model_hash = crc12_fold_byte(seed, d);
    pending_hashes.push_back(hash_result_t'{hash: model_hash, final_flag: last});
    bytes_sent++;
    if (last) msgs_closed++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result has been returned.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_hashes.size() != 0) @(negedge clk);
  endtask

  // One message of random bytes; extremes show up now and then.
  task automatic push_message(int unsigned len);
    byte_t d;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = byte_t'($urandom_range(255));
      endcase
      push_byte(d, i == 0, i == len - 1);
    end
  endtask

  // Directed cases: flags in every combination, nibble extremes, a known string.
  task automatic test_directed_bytes();
    byte_t ascii_msg [9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    // no first flag right after reset: folds into the reset value
    push_byte(8'h5A, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    // no first flag after a last byte: the held hash keeps folding
    push_byte(8'hFF, 1'b0, 1'b0);
    // both flags: one-byte message
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1);
    // nibble extremes inside one message
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h0F, 1'b0, 1'b0);
    push_byte(8'hF0, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h55, 1'b0, 1'b1);
    // plain ASCII string as a multi-byte message
    foreach (ascii_msg[i]) push_byte(ascii_msg[i], i == 0, i == 8);
    wait_drained();
  endtask

  // Mostly well-formed messages, some noise bytes with random flags, rare drains.
  task automatic test_random_traffic(int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_byte(byte_t'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 16) begin
        wait_drained();
      end else if (pick < 20) begin
        push_message($urandom_range(13, 40));
      end else begin
        push_message($urandom_range(1, 12));
      end
    end
    wait_drained();
  endtask

  // Sink holds off for a long stretch while the source keeps offering back to back,
  // so the pipeline fills and in_tready must drop.
  task automatic test_output_holdoff();
    int unsigned keep_src;
    keep_src = src_idle_pct;
    src_idle_pct = 0;
    @(posedge clk);
    holdoff_left = 150;
    @(negedge clk);
    push_message(40);
    src_idle_pct = keep_src;
    wait_drained();
  endtask

  // Source pauses mid-message until everything is back, then finishes the message.
  task automatic test_pause_until_drained();
    push_byte(8'hC3, 1'b1, 1'b0);
    push_byte(8'h3C, 1'b0, 1'b0);
    wait_drained();
    push_byte(8'h7E, 1'b0, 1'b1);
    wait_drained();
  endtask

  initial begin
    int unsigned guard;
    // synchronous reset, held low at the start, then released
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: slow sink
    src_idle_pct  = 28;
    sink_idle_pct = 82;
    test_directed_bytes();
    test_random_traffic(250);
    test_pause_until_drained();

    // phase 2: slow source
    src_idle_pct  = 82;
    sink_idle_pct = 28;
    test_random_traffic(250);
    test_output_holdoff();

    // phase 3: full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(250);
    test_pause_until_drained();

    // wait out anything still in flight, with a limit
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_hashes.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    if (pending_hashes.size() != 0) begin
      $display("testbench: timeout, %0d results never arrived", pending_hashes.size());
      $display("testbench: done, errors");
      $finish;
    end
    repeat (10) @(negedge clk);

    $display("testbench: %0d bytes sent, %0d message ends, %0d results checked",
             bytes_sent, msgs_closed, results_seen);
    $display("testbench: %0d input stall cycles seen during the output hold-off",
             stall_cycles);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
